@@ sv/pngcv_pkg.sv @@
// ============================================================================
// PNG chunk CRC validator package
// Shared types, constants and the CRC-32 byte step used by the validator.
// ============================================================================
package pngcv_pkg;

    localparam int unsigned IDX_W = 3;

    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    localparam logic [IDX_W-1:0] SIG_LAST   = IDX_W'(7);
    localparam logic [IDX_W-1:0] FIELD_LAST = IDX_W'(3);

    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_CRC,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_SIG   = 3'd1,
        ERR_TRUNC = 3'd2,
        ERR_CRC   = 3'd3,
        ERR_IEND  = 3'd4
    } err_t;

    typedef struct packed {
        logic file_valid;
        err_t code;
    } verdict_t;

    function automatic logic [7:0] sig_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'd137;
            3'd1:    v = 8'd80;
            3'd2:    v = 8'd78;
            3'd3:    v = 8'd71;
            3'd4:    v = 8'd13;
            3'd5:    v = 8'd10;
            3'd6:    v = 8'd26;
            3'd7:    v = 8'd10;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // Reflected CRC-32 update by one byte, eight shift steps of XOR logic.
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ sv/pngcv_parser.sv @@
// ============================================================================
// PNG chunk parser
// Walks signature and chunks, keeps the running CRC and forms the verdict.
// ============================================================================
module pngcv_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output pngcv_pkg::verdict_t verdict
);
    import pngcv_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    err_t             err_reg, err_next;
    logic [31:0]      len_reg, len_next;
    logic [31:0]      left_reg, left_next;
    logic [31:0]      crc_reg, crc_next;
    logic [31:0]      type_reg, type_next;
    logic [31:0]      stored_reg, stored_next;

    phase_t           phase_upd;
    logic [IDX_W-1:0] idx_upd;
    err_t             err_upd;
    logic [31:0]      crc_step;
    logic [31:0]      stored_shift;

    assign crc_step     = crc_byte(crc_reg, data_byte);
    assign stored_shift = {stored_reg[23:0], data_byte};

    always_comb
    begin
        phase_upd   = phase_reg;
        idx_upd     = idx_reg;
        err_upd     = err_reg;
        len_next    = len_reg;
        left_next   = left_reg;
        crc_next    = crc_reg;
        type_next   = type_reg;
        stored_next = stored_reg;
        case (phase_reg)
            PH_SIG:
            begin
                if (data_byte != sig_byte(idx_reg)) begin
                    if (err_reg == ERR_NONE) err_upd = ERR_SIG;
                    phase_upd = PH_DONE;
                end else if (idx_reg == SIG_LAST) begin
                    idx_upd   = '0;
                    phase_upd = PH_LEN;
                end else begin
                    idx_upd = idx_reg + IDX_W'(1);
                end
            end
            PH_LEN:
            begin
                len_next = {len_reg[23:0], data_byte};
                if (idx_reg == FIELD_LAST) begin
                    idx_upd   = '0;
                    left_next = {len_reg[23:0], data_byte};
                    crc_next  = CRC_INIT;
                    type_next = '0;
                    phase_upd = PH_TYPE;
                end else begin
                    idx_upd = idx_reg + IDX_W'(1);
                end
            end
            PH_TYPE:
            begin
                type_next = {type_reg[23:0], data_byte};
                crc_next  = crc_step;
                if (idx_reg == FIELD_LAST) begin
                    idx_upd     = '0;
                    stored_next = '0;
                    phase_upd   = (left_reg == 32'd0) ? PH_CRC : PH_DATA;
                end else begin
                    idx_upd = idx_reg + IDX_W'(1);
                end
            end
            PH_DATA:
            begin
                crc_next  = crc_step;
                left_next = left_reg - 32'd1;
                if (left_reg == 32'd1) phase_upd = PH_CRC;
            end
            PH_CRC:
            begin
                stored_next = stored_shift;
                if (idx_reg == FIELD_LAST) begin
                    idx_upd = '0;
                    if (~crc_reg != stored_shift) begin
                        if (err_reg == ERR_NONE) err_upd = ERR_CRC;
                        phase_upd = PH_DONE;
                    end else if (type_reg == TYPE_IEND) begin
                        if (len_reg != 32'd0) begin
                            if (err_reg == ERR_NONE) err_upd = ERR_IEND;
                        end
                        phase_upd = PH_DONE;
                    end else begin
                        len_next  = '0;
                        phase_upd = PH_LEN;
                    end
                end else begin
                    idx_upd = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                phase_upd = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        if (err_upd != ERR_NONE) begin
            verdict.code = err_upd;
        end else if (phase_upd == PH_DONE) begin
            verdict.code = ERR_NONE;
        end else if (phase_upd == PH_SIG) begin
            verdict.code = ERR_SIG;
        end else begin
            verdict.code = ERR_TRUNC;
        end
        verdict.file_valid = (verdict.code == ERR_NONE);
    end

    always_comb
    begin
        if (last_byte) begin
            phase_next = PH_SIG;
            idx_next   = '0;
            err_next   = ERR_NONE;
        end else begin
            phase_next = phase_upd;
            idx_next   = idx_upd;
            err_next   = err_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_SIG;
            idx_reg   <= '0;
            err_reg   <= ERR_NONE;
        end else if (step_en) begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en) begin
            len_reg    <= len_next;
            left_reg   <= left_next;
            crc_reg    <= crc_next;
            type_reg   <= type_next;
            stored_reg <= stored_next;
        end
    end

endmodule

@@ sv/png_chunk_crc_validator_top.sv @@
// The verdict reaches the master side via the input register and then the verdict register.
// Throughput: one byte per cycle while unstalled; the CRC-32 byte step is one combinational stage.
// A final beat waits in the input register only while an earlier verdict is still held.
// Reset clears the walk to the signature phase with no latched error and empties both registers.
// ============================================================================
// PNG chunk CRC validator top level
// Input beat register, chunk parser and verdict register on a stream interface.
// ============================================================================
module png_chunk_crc_validator_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] file_valid, [3:1] error_code, [7:4] zero
);
    import pngcv_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       proceed;
    logic       step_en;
    verdict_t   verdict;
    logic       out_valid_reg;
    verdict_t   out_reg;

    assign proceed  = !in_last_reg || !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && proceed;
    assign s_tready = !in_valid_reg || proceed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    pngcv_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .verdict   (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (step_en && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && in_last_reg) begin
            out_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.code, out_reg.file_valid};

    a_valid_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == ERR_NONE)))
        else $error("file_valid disagrees with error_code");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:1] <= ERR_IEND))
        else $error("error_code out of range");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(step_en && in_last_reg))
        else $error("verdict without a final beat");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !proceed) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("stalled final beat lost");

endmodule
